### rtl/core/q_encoded_word_decoder_macros.svh
// assertion macros for the q encoded word decoder
`ifndef Q_ENCODED_WORD_DECODER_MACROS_SVH
`define Q_ENCODED_WORD_DECODER_MACROS_SVH

// checked while out of reset
`define QEWD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qewd assertion failed");

// checked at every edge, reset included
`define QEWD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qewd assertion failed");

`endif

### rtl/core/qewd_pkg.sv
// shared types, constants and helper functions of the q encoded word decoder
package qewd_pkg;

  localparam int HOLD_DEPTH  = 32;
  localparam int CNT_W       = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W       = $clog2(HOLD_DEPTH);
  localparam int REM_W       = CNT_W + 1;
  localparam int PREFIX_LEN  = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] HOLD_FULL = CNT_W'(HOLD_DEPTH);
  localparam logic [CNT_W-1:0] GAP_LIMIT = CNT_W'(HOLD_DEPTH - 9);

  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_QM = 8'h3F;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_US = 8'h5F;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_HOLD
  } act_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] rel_n;
    act_e             act;
    logic [IDX_W-1:0] hold_idx;
    logic [7:0]       data;
    logic [CNT_W-1:0] tail_n;
    logic             last;
  } cmd_t;

  function automatic logic [7:0] open_mark(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h3D;
      4'd1:    ch = 8'h3F;
      4'd2:    ch = 8'h75;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h66;
      4'd5:    ch = 8'h2D;
      4'd6:    ch = 8'h38;
      4'd7:    ch = 8'h3F;
      4'd8:    ch = 8'h71;
      4'd9:    ch = 8'h3F;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
    return r;
  endfunction

  // valid flag on top, nibble below
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    logic r;
    r = c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    return r;
  endfunction

endpackage

### rtl/core/q_encoded_word_decoder.sv
// top level of the q encoded word decoder
//
// decodes "=?utf-8?Q?...?=" words in a byte stream and passes other text through
// input channel: in_valid_i / in_stall_o, one text byte per request with a last flag
// output channel: out_valid_o / out_stall_i, one result byte per request; run_end
//   marks the last result of an input byte, text_end the last result of the text
// lookahead bytes sit in a 32 entry hold buffer until a match is decided
// a byte's results pass through the command queue and then the output register
// throughput: plain text runs at one byte per cycle while out_stall_i is low; the back
//   end handles each result byte and each input byte that makes no result in turn,
//   and held bytes are released one at a time through the hold buffer read port
// a four entry command queue lets input keep flowing while results wait
// in_stall_o rises only when that queue is full
// a stalled output keeps its byte and flags unchanged until taken
// reset clears the match state, the queue and the output register; no memory
//   clearing pass is needed
module q_encoded_word_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qewd_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qewd_pkg::out_t out_o
);
  import qewd_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic full;
  logic head_valid;
  logic pop;

  assign push       = in_valid_i && !full;
  assign in_stall_o = full;

  qewd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .in_i   (in_i),
    .cmd_o  (front_cmd)
  );

  qewd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .dout_o  (head_cmd)
  );

  qewd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (out_o)
  );

endmodule

### rtl/core/qewd_front.sv
// front end: match state machine that turns each input byte into a command
module qewd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qewd_pkg::in_t in_i,
  output qewd_pkg::cmd_t cmd_o
);
  import qewd_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_PREFIX = 4'd1;
  localparam logic [3:0] PH_CR     = 4'd2;
  localparam logic [3:0] PH_SKIP   = 4'd3;
  localparam logic [3:0] PH_GAP    = 4'd4;
  localparam logic [3:0] PH_WORD   = 4'd5;
  localparam logic [3:0] PH_QMARK  = 4'd6;
  localparam logic [3:0] PH_EQ     = 4'd7;
  localparam logic [3:0] PH_EQ1    = 4'd8;

  logic [3:0]       ph_q, ph_d;
  logic [3:0]       pl_q, pl_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]       x_q, x_d;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] tail;
  logic [7:0]       c;
  logic [4:0]       hv;
  logic             rel;
  logic             retry;
  logic [3:0]       rph;
  act_e             act;
  logic [7:0]       data;

  always_comb begin
    c     = in_i.text_byte;
    hv    = hex_val(c);
    rel   = 1'b0;
    retry = 1'b0;
    rph   = PH_IDLE;
    act   = ACT_NONE;
    data  = c;
    ph_d  = ph_q;
    pl_d  = pl_q;
    cnt_d = cnt_q;
    x_d   = x_q;
    base  = cnt_q;
    case (ph_q)
      PH_IDLE: begin
        retry = 1'b1;
      end
      PH_WORD: begin
        retry = 1'b1;
        rph   = PH_WORD;
      end
      PH_PREFIX: begin
        if (pl_q < 4'(PREFIX_LEN) && to_lower(c) == open_mark(pl_q)) begin
          if (pl_q == 4'(PREFIX_LEN - 1)) begin
            cnt_d = '0;
            pl_d  = '0;
            ph_d  = PH_WORD;
          end else begin
            pl_d = pl_q + 4'd1;
            if (cnt_q < HOLD_FULL) begin
              act   = ACT_HOLD;
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end else begin
          rel   = 1'b1;
          retry = 1'b1;
          base  = '0;
        end
      end
      PH_CR: begin
        if (c == CH_LF) begin
          cnt_d = '0;
          pl_d  = '0;
          ph_d  = PH_SKIP;
        end else begin
          rel   = 1'b1;
          retry = 1'b1;
          base  = '0;
        end
      end
      PH_SKIP: begin
        if (!is_ws(c)) begin
          retry = 1'b1;
        end
      end
      PH_GAP: begin
        if (is_ws(c) && cnt_q < GAP_LIMIT) begin
          act   = ACT_HOLD;
          cnt_d = cnt_q + CNT_W'(1);
        end else if (c == CH_EQ) begin
          pl_d = 4'd1;
          ph_d = PH_PREFIX;
          if (cnt_q < HOLD_FULL) begin
            act   = ACT_HOLD;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end else begin
          rel   = 1'b1;
          retry = 1'b1;
          base  = '0;
        end
      end
      PH_QMARK: begin
        if (c == CH_EQ) begin
          cnt_d = '0;
          pl_d  = '0;
          ph_d  = PH_GAP;
        end else begin
          rel   = 1'b1;
          retry = 1'b1;
          rph   = PH_WORD;
          base  = '0;
        end
      end
      PH_EQ: begin
        if (hv[4]) begin
          x_d  = hv[3:0];
          ph_d = PH_EQ1;
          if (cnt_q < HOLD_FULL) begin
            act   = ACT_HOLD;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end else begin
          rel   = 1'b1;
          retry = 1'b1;
          rph   = PH_WORD;
          base  = '0;
        end
      end
      PH_EQ1: begin
        if (hv[4] && cnt_q >= CNT_W'(2)) begin
          act   = ACT_EMIT;
          data  = {x_q, hv[3:0]};
          cnt_d = '0;
          pl_d  = '0;
          ph_d  = PH_WORD;
        end else begin
          rel   = 1'b1;
          retry = 1'b1;
          rph   = PH_WORD;
          base  = '0;
        end
      end
      default: begin
        retry = 1'b1;
        base  = '0;
      end
    endcase

    // failing bytes, and bytes not consumed by a match phase, are judged afresh
    if (retry) begin
      cnt_d = base;
      pl_d  = '0;
      if (rph == PH_IDLE) begin
        if (c == CH_EQ || c == CH_CR) begin
          if (c == CH_EQ) begin
            pl_d = 4'd1;
            ph_d = PH_PREFIX;
          end else begin
            ph_d = PH_CR;
          end
          if (base < HOLD_FULL) begin
            act   = ACT_HOLD;
            cnt_d = base + CNT_W'(1);
          end
        end else begin
          act  = ACT_EMIT;
          ph_d = PH_IDLE;
        end
      end else begin
        if (c == CH_QM || c == CH_EQ) begin
          ph_d = (c == CH_QM) ? PH_QMARK : PH_EQ;
          if (base < HOLD_FULL) begin
            act   = ACT_HOLD;
            cnt_d = base + CNT_W'(1);
          end
        end else begin
          act  = ACT_EMIT;
          data = (c == CH_US) ? CH_SP : c;
          ph_d = PH_WORD;
        end
      end
    end

    // end of text flushes everything held
    tail = in_i.last ? cnt_d : '0;
    if (in_i.last) begin
      cnt_d = '0;
      pl_d  = '0;
      ph_d  = PH_IDLE;
    end
  end

  assign cmd_o.rel_n    = rel ? cnt_q : '0;
  assign cmd_o.act      = act;
  assign cmd_o.hold_idx = base[IDX_W-1:0];
  assign cmd_o.data     = data;
  assign cmd_o.tail_n   = tail;
  assign cmd_o.last     = in_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      pl_q  <= '0;
      cnt_q <= '0;
    end else if (push_i) begin
      ph_q  <= ph_d;
      pl_q  <= pl_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      x_q <= x_d;
    end
  end

endmodule

### rtl/core/qewd_queue.sv
// command queue between the front end and the back end
module qewd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qewd_pkg::cmd_t  din_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output qewd_pkg::cmd_t  dout_o
);
  import qewd_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= din_i;
    end
  end

endmodule

### rtl/core/qewd_back.sv
// back end: hold buffer memory and sequencer that emits the result bytes
module qewd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  qewd_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qewd_pkg::out_t out_o
);
  import qewd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RELA = 2'd1;
  localparam logic [1:0] ST_ACT  = 2'd2;
  localparam logic [1:0] ST_TAIL = 2'd3;

  logic [7:0]       hold_mem [HOLD_DEPTH];
  logic [1:0]       st_q, st_d;
  cmd_t             cmd_q;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             ov_q;
  logic [7:0]       byte_q;
  logic [7:0]       rd_q;
  logic             src_mem_q;
  logic             run_end_q;
  logic             text_end_q;

  cmd_t             cur;
  logic             have;
  logic [1:0]       cur_st;
  logic [1:0]       after;
  logic [IDX_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_nx;
  logic [REM_W-1:0] rem;
  logic             slot;
  logic             is_out;
  logic             fire;
  logic             phase_end;
  logic             rd_en;
  logic             wr_en;

  always_comb begin
    if (st_q == ST_IDLE) begin
      cur  = head_i;
      have = head_valid_i;
      ptr  = '0;
      rem  = REM_W'(head_i.rel_n) + REM_W'(head_i.tail_n)
           + REM_W'(head_i.act == ACT_EMIT);
      if (head_i.rel_n != '0) begin
        cur_st = ST_RELA;
      end else if (head_i.act != ACT_NONE) begin
        cur_st = ST_ACT;
      end else if (head_i.tail_n != '0) begin
        cur_st = ST_TAIL;
      end else begin
        cur_st = ST_IDLE;
      end
    end else begin
      cur    = cmd_q;
      have   = 1'b1;
      ptr    = ptr_q;
      rem    = rem_q;
      cur_st = st_q;
    end

    slot   = !ov_q || !out_stall_i;
    is_out = (cur_st == ST_RELA) || (cur_st == ST_TAIL)
          || (cur_st == ST_ACT && cur.act == ACT_EMIT);
    fire   = have && (!is_out || slot);
    pop_o  = fire && (st_q == ST_IDLE);
    rd_en  = fire && (cur_st == ST_RELA || cur_st == ST_TAIL);
    wr_en  = fire && cur_st == ST_ACT && cur.act == ACT_HOLD;
    ptr_nx = CNT_W'(ptr) + CNT_W'(1);

    case (cur_st)
      ST_RELA: phase_end = (ptr_nx == cur.rel_n);
      ST_TAIL: phase_end = (ptr_nx == cur.tail_n);
      default: phase_end = 1'b1;
    endcase

    case (cur_st)
      ST_RELA: begin
        if (cur.act != ACT_NONE) begin
          after = ST_ACT;
        end else if (cur.tail_n != '0) begin
          after = ST_TAIL;
        end else begin
          after = ST_IDLE;
        end
      end
      ST_ACT:  after = (cur.tail_n != '0) ? ST_TAIL : ST_IDLE;
      default: after = ST_IDLE;
    endcase

    st_d  = st_q;
    ptr_d = ptr_q;
    rem_d = rem_q;
    if (fire) begin
      st_d  = phase_end ? after : cur_st;
      ptr_d = phase_end ? '0 : ptr_nx[IDX_W-1:0];
      rem_d = is_out ? rem - REM_W'(1) : rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      ptr_q <= '0;
      rem_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      ptr_q <= ptr_d;
      rem_q <= rem_d;
      if (slot) begin
        ov_q <= fire && is_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (fire && is_out) begin
      byte_q     <= cur.data;
      src_mem_q  <= (cur_st != ST_ACT);
      run_end_q  <= (rem == REM_W'(1));
      text_end_q <= (rem == REM_W'(1)) && cur.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hold_mem[cur.hold_idx] <= cur.data;
    end
    if (rd_en) begin
      rd_q <= hold_mem[ptr];
    end
  end

  assign out_valid_o     = ov_q;
  assign out_o.out_byte  = src_mem_q ? rd_q : byte_q;
  assign out_o.run_end   = run_end_q;
  assign out_o.text_end  = text_end_q;

endmodule

### rtl/core/qewd_checker.sv
// port level checker for the q encoded word decoder and its bind
`include "q_encoded_word_decoder_macros.svh"

module qewd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input qewd_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input qewd_pkg::out_t out_o
);

  logic in_take;

  assign in_take = in_valid_i && !in_stall_o && in_i.last;

  // output register and queue come out of reset empty
  `QEWD_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o)

  // the end of the text is always the end of a run
  `QEWD_ASSERT(a_text_end_run, clk_i, rst_ni, out_valid_o && out_o.text_end |-> out_o.run_end)

  // a stalled result holds
  `QEWD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))

  // a final byte taken while no result is shown cannot show its result in the same cycle
  `QEWD_ASSERT(a_no_early_end, clk_i, rst_ni, in_take && !out_valid_o |-> !(out_valid_o && out_o.text_end))

endmodule

bind q_encoded_word_decoder qewd_checker u_qewd_checker (.*);
